// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the rtl files, used by the top file, sampled on clk_i
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define AIF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define AIF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/aif_pkg.sv
// ----------------------------------------------------------------------------
// aif_pkg
// shared types and constants of the integer alu with float fallback
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aif_pkg;

  localparam int WORD_WIDTH_DEF     = 32;
  localparam int SAFE_MUL_BOUND_DEF = 16384;
  localparam int QUEUE_DEPTH        = 4;
  localparam int OP_COUNT           = 13;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_DIV    = 4'd2,
    OP_REM    = 4'd3,
    OP_MOD    = 4'd4,
    OP_AND    = 4'd5,
    OP_OR     = 4'd6,
    OP_XOR    = 4'd7,
    OP_ASHIFT = 4'd8,
    OP_LSHIFT = 4'd9,
    OP_MUL    = 4'd10,
    OP_NEG    = 4'd11,
    OP_NOT    = 4'd12
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NEEDS_FLOAT = 2'd1,
    ST_DIV_ZERO    = 2'd2
  } status_e;

  // classification handed from front to back
  typedef struct packed {
    op_e     op;
    status_e st;
  } cls_t;

endpackage

// File: sv/aif_front.sv
// ----------------------------------------------------------------------------
// aif_front
// accepts words, decodes the opcode and flags early failures
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aif_front #(
  parameter int W            = aif_pkg::WORD_WIDTH_DEF,
  parameter int SafeMulBound = aif_pkg::SAFE_MUL_BOUND_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         req_type_i,
  input  logic signed [31:0] left_operand_i,
  input  logic signed [31:0] right_operand_i,
  output logic               push_o,
  input  logic               full_i,
  output aif_pkg::cls_t      cls_o,
  output logic signed [W-1:0] a_o,
  output logic signed [W-1:0] b_o
);
  import aif_pkg::*;

  localparam logic signed [65:0] Bound = 66'(SafeMulBound);

  logic               vld_q;
  cls_t               cls_q, cls_d;
  logic signed [W-1:0] a_q, b_q, a_w, b_w;
  logic signed [65:0] ax, bx;
  logic               bad, big;
  op_e                op;

  always_comb begin
    a_w = W'(left_operand_i);
    b_w = W'(right_operand_i);
    ax  = 66'(a_w);
    bx  = 66'(b_w);
    big = (ax >= Bound) || (ax <= -Bound) || (bx >= Bound) || (bx <= -Bound);
    bad = req_type_i > 4'(OP_COUNT - 1);
    op  = op_e'(req_type_i);
    cls_d.op = op;
    priority if (bad) begin
      cls_d.st = ST_NEEDS_FLOAT;
    end else if ((op == OP_DIV || op == OP_REM || op == OP_MOD) && b_w == '0) begin
      cls_d.st = ST_DIV_ZERO;
    end else if (op == OP_MUL && big) begin
      cls_d.st = ST_NEEDS_FLOAT;
    end else begin
      cls_d.st = ST_OK;
    end
  end

  assign push_o     = vld_q && !full_i;
  assign in_stall_o = vld_q && full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      cls_q <= cls_d;
      a_q   <= a_w;
      b_q   <= b_w;
    end
  end

  assign cls_o = cls_q;
  assign a_o   = a_q;
  assign b_o   = b_q;

endmodule

// File: sv/aif_queue.sv
// ----------------------------------------------------------------------------
// aif_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aif_queue #(
  parameter int DW    = 8,
  parameter int Depth = aif_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [DW-1:0] rdata_o
);
  import aif_pkg::*;

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [DW-1:0] mem_q [Depth];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = cnt_q == CW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// File: sv/aif_back.sv
// ----------------------------------------------------------------------------
// aif_back
// execution pipeline: simple ops and multiply, one quotient bit a stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aif_back #(
  parameter int W = aif_pkg::WORD_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  output logic                pop_o,
  input  aif_pkg::cls_t       cls_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [W-1:0]        res_o,
  output aif_pkg::status_e    st_o
);
  import aif_pkg::*;

  localparam int WP = W + 1;
  localparam int AW = $clog2(W);
  localparam int NS = W + 2;

  logic          vld_q [NS];
  op_e           op_q  [NS];
  status_e       st_q  [NS];
  logic [W-1:0]  res_q [NS];
  logic          sa_q  [NS];
  logic          sb_q  [NS];
  logic [W-1:0]  bv_q  [NS];
  logic [W-1:0]  dvs_q [NS];
  logic [W-1:0]  dvd_q [NS];
  logic [W-1:0]  rem_q [NS];
  logic [W-1:0]  quo_q [NS];
  logic [63:0]   prod_q;
  logic          adv;

  // whole pipe moves unless the output word is held
  assign adv   = !vld_q[NS-1] || !out_stall_i;
  assign pop_o = adv && !empty_i;

  // stage 0 inputs
  logic signed [W:0] ax, bx, sum, dif, ng;
  logic [W:0]        nmag;
  logic              sh_big;
  logic [AW-1:0]     amt;
  logic [W-1:0]      shl, asr, lsr, res0, dvd0, dvs0;
  logic [31:0]       ma, mb;
  logic [63:0]       prod0;
  status_e           st0;

  always_comb begin
    ax     = WP'(a_i);
    bx     = WP'(b_i);
    sum    = ax + bx;
    dif    = ax - bx;
    ng     = -ax;
    nmag   = b_i[W-1] ? WP'(-bx) : WP'(bx);
    sh_big = nmag >= WP'(W);
    amt    = nmag[AW-1:0];
    shl    = sh_big ? '0 : W'(a_i << amt);
    asr    = sh_big ? {W{a_i[W-1]}} : W'(a_i >>> amt);
    lsr    = sh_big ? '0 : W'(a_i >> amt);
    ma     = 32'(a_i[W-1] ? ng : ax);
    mb     = 32'(b_i[W-1] ? WP'(-bx) : bx);
    prod0  = 64'(ma) * 64'(mb);
    dvd0   = W'(a_i[W-1] ? -a_i : a_i);
    dvs0   = W'(b_i[W-1] ? -b_i : b_i);
    st0    = cls_i.st;
    res0   = '0;
    unique case (cls_i.op)
      OP_ADD: begin
        res0 = sum[W-1:0];
        if (sum[W] != sum[W-1]) st0 = ST_NEEDS_FLOAT;
      end
      OP_SUB: begin
        res0 = dif[W-1:0];
        if (dif[W] != dif[W-1]) st0 = ST_NEEDS_FLOAT;
      end
      OP_NEG: begin
        res0 = ng[W-1:0];
        if (ng[W] != ng[W-1]) st0 = ST_NEEDS_FLOAT;
      end
      OP_AND:    res0 = a_i & b_i;
      OP_OR:     res0 = a_i | b_i;
      OP_XOR:    res0 = a_i ^ b_i;
      OP_NOT:    res0 = ~a_i;
      OP_ASHIFT: res0 = b_i[W-1] ? asr : shl;
      OP_LSHIFT: res0 = b_i[W-1] ? lsr : shl;
      OP_DIV, OP_REM, OP_MOD, OP_MUL: res0 = '0;
      default:   res0 = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && !empty_i) begin
      op_q[0]  <= cls_i.op;
      st_q[0]  <= st0;
      res_q[0] <= res0;
      sa_q[0]  <= a_i[W-1];
      sb_q[0]  <= b_i[W-1];
      bv_q[0]  <= b_i;
      dvs_q[0] <= dvs0;
      dvd_q[0] <= dvd0;
      rem_q[0] <= '0;
      quo_q[0] <= '0;
      prod_q   <= prod0;
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_stage
    status_e      st_d;
    logic [W-1:0] res_d, rem_d, quo_d, dvd_d;

    if (s <= W) begin : g_iter
      logic [W-1:0] rem_sh, prod_s;
      logic [64:0]  lim;
      logic         ge, pneg, pfit;

      always_comb begin
        rem_sh = {rem_q[s-1][W-2:0], dvd_q[s-1][W-1]};
        ge     = rem_sh >= dvs_q[s-1];
        rem_d  = ge ? rem_sh - dvs_q[s-1] : rem_sh;
        quo_d  = {quo_q[s-1][W-2:0], ge};
        dvd_d  = dvd_q[s-1] << 1;
        st_d   = st_q[s-1];
        res_d  = res_q[s-1];
        pneg   = sa_q[s-1] ^ sb_q[s-1];
        lim    = 65'(1) << (W - 1);
        pfit   = pneg ? ({1'b0, prod_q} <= lim) : ({1'b0, prod_q} < lim);
        prod_s = W'(pneg ? (64'd0 - prod_q) : prod_q);
        // multiply range check sits in the first divide stage
        if (s == 1 && op_q[s-1] == OP_MUL && st_q[s-1] == ST_OK) begin
          if (pfit) res_d = prod_s;
          else st_d = ST_NEEDS_FLOAT;
        end
      end
    end else begin : g_fin
      logic [W-1:0] q, r;
      logic         qneg, rnz;

      always_comb begin
        qneg  = sa_q[s-1] ^ sb_q[s-1];
        rnz   = rem_q[s-1] != '0;
        q     = qneg ? -quo_q[s-1] : quo_q[s-1];
        r     = sa_q[s-1] ? -rem_q[s-1] : rem_q[s-1];
        st_d  = st_q[s-1];
        res_d = res_q[s-1];
        rem_d = rem_q[s-1];
        quo_d = quo_q[s-1];
        dvd_d = dvd_q[s-1];
        if (st_q[s-1] == ST_OK) begin
          unique case (op_q[s-1])
            OP_DIV: begin
              if (rnz || (!qneg && quo_q[s-1][W-1])) st_d = ST_NEEDS_FLOAT;
              else res_d = q;
            end
            OP_REM: res_d = r;
            OP_MOD: res_d = r + ((rnz && (sa_q[s-1] != sb_q[s-1])) ? bv_q[s-1] : '0);
            default: res_d = res_q[s-1];
          endcase
        end
        if (st_d != ST_OK) res_d = '0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv && vld_q[s-1]) begin
        op_q[s]  <= op_q[s-1];
        st_q[s]  <= st_d;
        res_q[s] <= res_d;
        sa_q[s]  <= sa_q[s-1];
        sb_q[s]  <= sb_q[s-1];
        bv_q[s]  <= bv_q[s-1];
        dvs_q[s] <= dvs_q[s-1];
        dvd_q[s] <= dvd_d;
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
      end
    end
  end

  assign out_valid_o = vld_q[NS-1];
  assign res_o       = res_q[NS-1];
  assign st_o        = st_q[NS-1];

endmodule

// File: sv/integer_alu_float_fallback_top.sv
// ----------------------------------------------------------------------------
// integer_alu_float_fallback_top
// integer alu that reports results it cannot give exactly
// ----------------------------------------------------------------------------
// One word in (opcode and two signed operands) gives one word out (result
// and status). A new word can be taken every cycle while in_stall_o is low.
// The divider sets the pipeline length, as it resolves one quotient bit per
// pipeline stage. Every opcode runs through the same pipeline, so results
// leave in order. A four word queue sits between the decode front and the
// execution back, so input keeps flowing for a while after the output side
// stalls.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module integer_alu_float_fallback_top #(
  parameter int WordWidth    = aif_pkg::WORD_WIDTH_DEF,
  parameter int SafeMulBound = aif_pkg::SAFE_MUL_BOUND_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         req_type_i,
  input  logic signed [31:0] left_operand_i,
  input  logic signed [31:0] right_operand_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic [1:0]         status_o
);
  import aif_pkg::*;

  localparam int DW = $bits(cls_t) + 2 * WordWidth;

  // front to queue
  logic                        push, full;
  cls_t                        f_cls;
  logic signed [WordWidth-1:0] f_a, f_b;

  // queue to back
  logic                        pop, empty;
  logic [DW-1:0]               q_data;
  cls_t                        b_cls;
  logic signed [WordWidth-1:0] b_a, b_b;

  logic [WordWidth-1:0]        res;
  status_e                     st;

  // decode, operand sizing and early status checks
  aif_front #(
    .W            (WordWidth),
    .SafeMulBound (SafeMulBound)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .left_operand_i  (left_operand_i),
    .right_operand_i (right_operand_i),
    .push_o          (push),
    .full_i          (full),
    .cls_o           (f_cls),
    .a_o             (f_a),
    .b_o             (f_b)
  );

  // decouples decode from execution
  aif_queue #(
    .DW    (DW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_cls, f_a, f_b}),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (q_data)
  );

  assign {b_cls, b_a, b_b} = q_data;

  // execution pipeline, last stage is the output register
  aif_back #(
    .W (WordWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .cls_i       (b_cls),
    .a_i         (b_a),
    .b_i         (b_b),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res),
    .st_o        (st)
  );

  // word result sign-extended or cut to the 32 bit port
  assign result_value_o = 32'(signed'(res));
  assign status_o       = st;

  // any failing status comes with a zero value
  `AIF_ASSERT(a_zero_on_fail, (out_valid_o && status_o != ST_OK) |-> (result_value_o == '0), "nonzero result with failing status")
  // status code three is never produced
  `AIF_ASSERT(a_status_code, out_valid_o |-> (status_o != 2'd3), "undefined status code")
  // nothing leaves right after reset
  `AIF_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "output valid right after reset")

endmodule

// File: test/integer_alu_float_fallback_top_test.sv
// ----------------------------------------------------------------------------
// integer_alu_float_fallback_top_test
// self-checking bench for the integer alu with float fallback
// ----------------------------------------------------------------------------
// Drives opcode and operand words through the valid/stall handshake. Each
// accepted word is predicted in-bench and queued, and each result word is
// compared in order against the queue. The run covers directed corner
// cases, random words under three idling mixes, a long output hold-off and
// a drain pause.
`timescale 1ns / 1ps

module integer_alu_float_fallback_top_test;
  import aif_pkg::*;

  localparam int WW      = 32;
  localparam int MUL_LIM = 16384;
  localparam int LATENCY = WW + 4;
  localparam int LIMIT   = 400000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [3:0]         req_type_i;
  logic signed [31:0] left_operand_i;
  logic signed [31:0] right_operand_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] result_value_o;
  logic [1:0]         status_o;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         st;
  } alu_result_t;

  alu_result_t pending_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int mismatches;
  int results_seen;
  int cycle_count;
  int words_sent;

  integer_alu_float_fallback_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // predicted result of one word
  function automatic alu_result_t alu_predict(logic [3:0] op, logic signed [31:0] a32,
                                              logic signed [31:0] b32);
    alu_result_t res;
    longint a;
    longint b;
    longint r;
    logic [1:0] st;
    int n;
    a = a32;
    b = b32;
    r = 0;
    st = ST_OK;
    case (op)
      OP_ADD: begin
        r = a + b;
        if (r != longint'(int'(r))) st = ST_NEEDS_FLOAT;
      end
      OP_SUB: begin
        r = a - b;
        if (r != longint'(int'(r))) st = ST_NEEDS_FLOAT;
      end
      OP_DIV: begin
        if (b == 0) st = ST_DIV_ZERO;
        else if (a % b != 0) st = ST_NEEDS_FLOAT;
        else begin
          r = a / b;
          if (r != longint'(int'(r))) st = ST_NEEDS_FLOAT;
        end
      end
      OP_REM: begin
        if (b == 0) st = ST_DIV_ZERO;
        else r = a % b;
      end
      OP_MOD: begin
        if (b == 0) st = ST_DIV_ZERO;
        else begin
          r = a % b;
          // only a nonzero remainder of the wrong sign is adjusted
          if (r != 0 && ((r < 0) != (b < 0))) r = r + b;
        end
      end
      OP_AND: r = a & b;
      OP_OR:  r = a | b;
      OP_XOR: r = a ^ b;
      OP_ASHIFT, OP_LSHIFT: begin
        if (b >= 0) begin
          r = (b >= WW) ? 0 : longint'(a32 <<< b);
        end else begin
          n = (b <= -WW) ? WW : int'(-b);
          if (n >= WW) r = (op == OP_ASHIFT && a < 0) ? -1 : 0;
          else if (op == OP_ASHIFT) r = longint'(a32 >>> n);
          else r = longint'($signed(32'(a32) >> n));
        end
      end
      OP_MUL: begin
        if (a < MUL_LIM && a > -MUL_LIM && b < MUL_LIM && b > -MUL_LIM) begin
          r = a * b;
          if (r != longint'(int'(r))) st = ST_NEEDS_FLOAT;
        end else st = ST_NEEDS_FLOAT;
      end
      OP_NEG: begin
        r = -a;
        if (r != longint'(int'(r))) st = ST_NEEDS_FLOAT;
      end
      OP_NOT: r = ~a;
      default: st = ST_NEEDS_FLOAT;
    endcase
    if (st != ST_OK) r = 0;
    res.value = r[31:0];
    res.st = st;
    return res;
  endfunction

  // offer one word, hold it until accepted; valid drops only while idling
  task automatic send_word(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= op;
    left_operand_i  <= a;
    right_operand_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(alu_predict(op, a, b));
    words_sent++;
  endtask

  // random operand biased toward edges
  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom_range(40))) - 20;
      3: return $signed(32'($urandom_range(2 * MUL_LIM))) - MUL_LIM;
      4: return $signed(32'($urandom_range(80))) - 40;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic send_random(int count);
    logic [3:0] op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    repeat (count) begin
      // mostly legal opcodes, a few unknown ones
      op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 13)) : 4'($urandom_range(12));
      a = pick_operand();
      b = pick_operand();
      // make some divides exact
      if (op == OP_DIV && $urandom_range(1) && b != 0 && b != -1)
        a = b * ($signed(32'($urandom_range(20))) - 10);
      send_word(op, a, b);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic signed [31:0] edges[4];
    edges = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int op = 0; op <= 15; op++) send_word(4'(op), edges[op % 4], edges[(op + 1) % 4]);
    send_word(OP_DIV, 32'sh8000_0000, -1);
    send_word(OP_DIV, 7, 2);
    send_word(OP_MOD, -6, 3);
    send_word(OP_MOD, -7, 3);
    send_word(OP_ASHIFT, -8, -40);
    send_word(OP_LSHIFT, -8, -1);
    send_word(OP_ASHIFT, 1, 31);
    send_word(OP_MUL, MUL_LIM - 1, -(MUL_LIM - 1));
    send_word(OP_MUL, MUL_LIM, 1);
    wait_drained();
  endtask

  task automatic test_random_mixes();
    send_idle_pct = 15; recv_idle_pct = 52;
    send_random(220);
    send_idle_pct = 52; recv_idle_pct = 15;
    send_random(220);
    send_idle_pct = 0; recv_idle_pct = 0;
    send_random(200);
  endtask

  // receiver holds off while the sender keeps offering, then a drain pause
  task automatic test_backpressure();
    hold_cycles = 120;
    send_random(60);
    wait_drained();
    send_random(20);
  endtask

  // receiver stall with long hold-off stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    alu_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %0d", result_value_o);
      end else begin
        exp_res = pending_results.pop_front();
        if (exp_res.value !== result_value_o || exp_res.st !== status_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                     exp_res.value, exp_res.st, result_value_o, status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = '0;
    left_operand_i = '0;
    right_operand_i = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    mismatches = 0;
    results_seen = 0;
    cycle_count = 0;
    words_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_mixes();
    test_backpressure();
    wait_drained();
    if (pending_results.size() != 0) mismatches++;
    $display("sent %0d words over all opcodes, edge operands and shift saturation;", words_sent);
    $display("checked %0d results under idling, hold-off and drain phases", results_seen);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
